@@ hw/rtl/gms_pkg.sv @@
// ----------------------------------------------------------------------------
// gms_pkg
// Shared constants, codes and control/status types of the gradient monitor
// smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

   // Grid capacity
   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 64;
   localparam int GRID_CAP = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(GRID_CAP);

   // Field widths
   localparam int ROW_W   = 9;
   localparam int COL_W   = 7;
   localparam int GAIN_W  = 10;
   localparam int PASS_W  = 4;
   localparam int PHI_W   = 16;
   localparam int OMEGA_W = 24;

   // Square root unit: 48-bit radicand, one result bit per cycle
   localparam int RAD_W      = 2 * OMEGA_W;
   localparam int SQRT_STEPS = OMEGA_W;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

   // Request kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_ROWS   = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_GAIN   = 2'd2;
   localparam logic [1:0] REG_PASSES = 2'd3;

   // Omega store read address select
   localparam logic [1:0] RD_SEL_READ  = 2'd0;
   localparam logic [1:0] RD_SEL_TAP   = 2'd1;
   localparam logic [1:0] RD_SEL_POINT = 2'd2;

   // Neighbor direction of one of the nine stencil taps
   typedef struct packed {
      logic di_neg;
      logic di_pos;
      logic dj_neg;
      logic dj_pos;
   } tap_dir_type;

   function automatic tap_dir_type tap_dir(input logic [3:0] tap);
      tap_dir_type d;
      d = '0;
      case (tap)
         4'd0: begin d.di_neg = 1'b1; d.dj_neg = 1'b1; end
         4'd1: begin d.di_neg = 1'b1; end
         4'd2: begin d.di_neg = 1'b1; d.dj_pos = 1'b1; end
         4'd3: begin d.dj_neg = 1'b1; end
         4'd5: begin d.dj_pos = 1'b1; end
         4'd6: begin d.di_pos = 1'b1; d.dj_neg = 1'b1; end
         4'd7: begin d.di_pos = 1'b1; end
         4'd8: begin d.di_pos = 1'b1; d.dj_pos = 1'b1; end
         default: d = '0;
      endcase
      return d;
   endfunction

   // Controller to datapath
   typedef struct packed {
      logic       load_wr;
      logic       read_start;
      logic       rsp_read;
      logic       rsp_done;
      logic       point_init;
      logic       point_next;
      logic       tap_next;
      logic       grad_capture;
      logic       grad_square;
      logic       grad_scale;
      logic       sqrt_start;
      logic       omega_wr_grad;
      logic       smooth_acc;
      logic       scratch_wr;
      logic       omega_wr_copy;
      logic       pass_init;
      logic       pass_next;
      logic       peak_clear;
      logic       peak_update;
      logic [1:0] omega_rd_sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic load_end;
      logic grad_tap_last;
      logic smooth_tap_last;
      logic last_point;
      logic last_pass;
      logic no_passes;
      logic sqrt_done;
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/gms_isqrt.sv @@
// ----------------------------------------------------------------------------
// gms_isqrt
// Truncating integer square root, digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_isqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [gms_pkg::RAD_W-1:0]    radicand,
   output logic                              done,
   output logic [gms_pkg::OMEGA_W-1:0]       root
);

   localparam int REM_W = gms_pkg::OMEGA_W + 2;
   localparam int SHF_W = REM_W + 2;

   logic                              run_ff;
   logic [gms_pkg::SQRT_CNT_W-1:0]    cnt_ff;
   logic [gms_pkg::RAD_W-1:0]         rad_ff;
   logic [REM_W-1:0]                  rem_ff;
   logic [gms_pkg::OMEGA_W-1:0]       root_ff;

   logic [SHF_W-1:0]                  shifted;
   logic [SHF_W-1:0]                  trial;
   logic                              fits;
   logic [REM_W-1:0]                  rem_in;

   // One restoring step: bring down two radicand bits, try root*4+1
   assign shifted = {rem_ff, rad_ff[gms_pkg::RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign fits    = (shifted >= trial);
   assign rem_in  = fits ? REM_W'(shifted - trial) : shifted[REM_W-1:0];

   assign done = run_ff && (cnt_ff == gms_pkg::SQRT_CNT_W'(gms_pkg::SQRT_STEPS - 1));
   assign root = root_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (done) begin
            run_ff <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[gms_pkg::RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[gms_pkg::OMEGA_W-2:0], fits};
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/gms_datapath.sv @@
// ----------------------------------------------------------------------------
// gms_datapath
// Sample, monitor and scratch stores, grid walk counters, gradient and
// smoothing arithmetic, peak tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gms_pkg::cmd_type                cmd,
   output gms_pkg::status_type                  status,
   input  wire logic [gms_pkg::ROW_W-1:0]       row_count,
   input  wire logic [gms_pkg::COL_W-1:0]       column_count,
   input  wire logic [gms_pkg::GAIN_W-1:0]      gradient_gain,
   input  wire logic [gms_pkg::PASS_W-1:0]      smoothing_passes,
   input  wire logic [gms_pkg::PHI_W-1:0]       phi_value,
   output logic [gms_pkg::OMEGA_W-1:0]          omega_value,
   output logic [gms_pkg::OMEGA_W-1:0]          omega_peak,
   output logic                                 grid_done,
   output logic                                 last_value
);

   localparam int AW    = gms_pkg::ADDR_W;
   localparam int TW    = AW + 1;
   localparam int OW    = gms_pkg::OMEGA_W;
   localparam int PW    = gms_pkg::PHI_W;
   localparam int SUM_W = 2 * (PW + 1) + 2;
   localparam int PRD_W = gms_pkg::RAD_W - 2;
   localparam int ACC_W = OW + 4;

   // Grid size in use
   logic [gms_pkg::ROW_W-1:0] rows_used;
   logic [gms_pkg::COL_W-1:0] cols_used;
   logic [TW-1:0]             total;
   logic [AW-1:0]             cols_a;

   always_comb begin
      if (row_count < gms_pkg::ROW_W'(3)) begin
         rows_used = gms_pkg::ROW_W'(3);
      end else if (row_count > gms_pkg::ROW_W'(gms_pkg::MAX_ROWS)) begin
         rows_used = gms_pkg::ROW_W'(gms_pkg::MAX_ROWS);
      end else begin
         rows_used = row_count;
      end
      if (column_count < gms_pkg::COL_W'(3)) begin
         cols_used = gms_pkg::COL_W'(3);
      end else if (column_count > gms_pkg::COL_W'(gms_pkg::MAX_COLS)) begin
         cols_used = gms_pkg::COL_W'(gms_pkg::MAX_COLS);
      end else begin
         cols_used = column_count;
      end
   end

   assign total  = TW'(rows_used) * TW'(cols_used);
   assign cols_a = AW'(cols_used);

   // Load and read positions
   logic [AW-1:0] load_pos_ff;
   logic [AW-1:0] read_pos_ff;
   logic [AW-1:0] rd_pos;
   logic [TW-1:0] rd_pos_inc;
   logic          load_end;
   logic          rd_last_ff;

   assign load_end   = ({1'b0, load_pos_ff} + TW'(1)) >= total;
   assign rd_pos     = ({1'b0, read_pos_ff} >= total) ? '0 : read_pos_ff;
   assign rd_pos_inc = {1'b0, rd_pos} + TW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         read_pos_ff <= '0;
      end else begin
         if (cmd.load_wr) begin
            load_pos_ff <= load_end ? '0 : load_pos_ff + 1'b1;
            if (load_end) begin
               read_pos_ff <= '0;
            end
         end
         if (cmd.read_start) begin
            read_pos_ff <= (rd_pos_inc >= total) ? '0 : rd_pos_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         rd_last_ff <= ({1'b0, rd_pos} == (total - TW'(1)));
      end
   end

   // Grid walk: row, column, linear address, tap
   logic [gms_pkg::ROW_W-1:0] i_ff;
   logic [gms_pkg::COL_W-1:0] j_ff;
   logic [AW-1:0]             k_ff;
   logic [3:0]                tap_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          acc_add;

   logic row_first, row_last, col_first, col_last;
   logic row_edge, col_edge, corner;

   assign row_first = (i_ff == '0);
   assign row_last  = (i_ff == rows_used - 1'b1);
   assign col_first = (j_ff == '0);
   assign col_last  = (j_ff == cols_used - 1'b1);
   assign row_edge  = row_first | row_last;
   assign col_edge  = col_first | col_last;
   assign corner    = row_edge & col_edge;

   always_ff @(posedge clock) begin
      if (cmd.point_init) begin
         i_ff   <= '0;
         j_ff   <= '0;
         k_ff   <= '0;
         tap_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.point_next) begin
         if (col_last) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
         k_ff   <= k_ff + 1'b1;
         tap_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.tap_next) begin
            tap_ff <= tap_ff + 1'b1;
         end
         if (cmd.smooth_acc) begin
            acc_ff <= acc_ff + acc_add;
         end
      end
   end

   // Smoothing pass counter
   logic [gms_pkg::PASS_W-1:0] pass_ff;

   always_ff @(posedge clock) begin
      if (cmd.pass_init) begin
         pass_ff <= '0;
      end else if (cmd.pass_next) begin
         pass_ff <= pass_ff + 1'b1;
      end
   end

   // Gradient neighbor addresses: one-sided at the grid border
   logic [AW-1:0] grad_addr;

   always_comb begin
      case (tap_ff[1:0])
         2'd0:    grad_addr = row_first ? k_ff : k_ff - cols_a;
         2'd1:    grad_addr = row_last  ? k_ff : k_ff + cols_a;
         2'd2:    grad_addr = col_first ? k_ff : k_ff - 1'b1;
         2'd3:    grad_addr = col_last  ? k_ff : k_ff + 1'b1;
         default: grad_addr = k_ff;
      endcase
   end

   // Smoothing tap: weight as a shift (1, 2 or 4) and neighbor address
   gms_pkg::tap_dir_type dir;
   logic                 di_zero, dj_zero;
   logic                 w_en;
   logic [1:0]           w_shift;
   logic [AW-1:0]        row_addr;
   logic [AW-1:0]        tap_addr;

   assign dir     = gms_pkg::tap_dir(tap_ff);
   assign di_zero = !(dir.di_neg | dir.di_pos);
   assign dj_zero = !(dir.dj_neg | dir.dj_pos);

   always_comb begin
      if (corner) begin
         w_en    = 1'b0;
         w_shift = 2'd0;
      end else if (row_edge) begin
         w_en    = di_zero;
         w_shift = {1'b0, dj_zero};
      end else if (col_edge) begin
         w_en    = dj_zero;
         w_shift = {1'b0, di_zero};
      end else begin
         w_en    = 1'b1;
         w_shift = 2'({1'b0, di_zero} + {1'b0, dj_zero});
      end
   end

   always_comb begin
      if (dir.di_neg) begin
         row_addr = k_ff - cols_a;
      end else if (dir.di_pos) begin
         row_addr = k_ff + cols_a;
      end else begin
         row_addr = k_ff;
      end
      if (!w_en) begin
         tap_addr = k_ff;
      end else if (dir.dj_neg) begin
         tap_addr = row_addr - 1'b1;
      end else if (dir.dj_pos) begin
         tap_addr = row_addr + 1'b1;
      end else begin
         tap_addr = row_addr;
      end
   end

   // Stores
   logic [PW-1:0] phi_mem [gms_pkg::GRID_CAP];
   logic [OW-1:0] omega_mem [gms_pkg::GRID_CAP];
   logic [OW-1:0] scratch_mem [gms_pkg::GRID_CAP];

   logic [PW-1:0] phi_rdata_ff;
   logic [OW-1:0] omega_rdata_ff;
   logic [OW-1:0] scratch_rdata_ff;
   logic [AW-1:0] omega_raddr;
   logic          omega_we;
   logic [OW-1:0] omega_wdata;
   logic [OW-1:0] smooth_result;
   logic [OW-1:0] root;

   always_comb begin
      case (cmd.omega_rd_sel)
         gms_pkg::RD_SEL_READ:  omega_raddr = rd_pos;
         gms_pkg::RD_SEL_TAP:   omega_raddr = tap_addr;
         gms_pkg::RD_SEL_POINT: omega_raddr = k_ff;
         default:               omega_raddr = k_ff;
      endcase
   end

   assign omega_we    = cmd.omega_wr_grad | (cmd.omega_wr_copy & !corner);
   assign omega_wdata = cmd.omega_wr_grad ? root : scratch_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         phi_mem[load_pos_ff] <= phi_value;
      end
      phi_rdata_ff <= phi_mem[grad_addr];
   end

   always_ff @(posedge clock) begin
      if (omega_we) begin
         omega_mem[k_ff] <= omega_wdata;
      end
      omega_rdata_ff <= omega_mem[omega_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scratch_wr) begin
         scratch_mem[k_ff] <= smooth_result;
      end
      scratch_rdata_ff <= scratch_mem[k_ff];
   end

   // Smoothing accumulate and normalize
   assign acc_add       = w_en ? (ACC_W'(omega_rdata_ff) << w_shift) : '0;
   assign smooth_result = (row_edge | col_edge) ? acc_ff[OW+1:2] : acc_ff[OW+3:4];

   // Gradient: captured neighbors, squared differences, gain scaling
   logic signed [PW-1:0]     phi_tap_ff [4];
   logic signed [PW:0]       dx, dy;
   logic signed [2*PW+1:0]   sq_x, sq_y;
   logic [SUM_W-1:0]         term_x, term_y;
   logic [SUM_W-1:0]         grad_sum_ff;
   logic [PRD_W-1:0]         gain_prod;
   logic [gms_pkg::RAD_W-1:0] radicand_ff;
   logic                     sqrt_done;

   assign dx     = {phi_tap_ff[1][PW-1], phi_tap_ff[1]} - {phi_tap_ff[0][PW-1], phi_tap_ff[0]};
   assign dy     = {phi_tap_ff[3][PW-1], phi_tap_ff[3]} - {phi_tap_ff[2][PW-1], phi_tap_ff[2]};
   assign sq_x   = dx * dx;
   assign sq_y   = dy * dy;
   assign term_x = row_edge ? {sq_x, 2'b00} : SUM_W'(sq_x);
   assign term_y = col_edge ? {sq_y, 2'b00} : SUM_W'(sq_y);

   assign gain_prod = PRD_W'(gradient_gain) * PRD_W'(grad_sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.grad_capture) begin
         phi_tap_ff[tap_ff[1:0]] <= phi_rdata_ff;
      end
      if (cmd.grad_square) begin
         grad_sum_ff <= term_x + term_y;
      end
      if (cmd.grad_scale) begin
         radicand_ff <= {gain_prod + (PRD_W'(1) << 30), 2'b00};
      end
   end

   gms_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // Peak of the smoothed grid
   logic [OW-1:0] peak_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.peak_clear) begin
         peak_ff <= '0;
      end else if (cmd.peak_update && (omega_rdata_ff > peak_ff)) begin
         peak_ff <= omega_rdata_ff;
      end
   end

   // Result register
   logic [OW-1:0] omega_out_ff;
   logic          done_out_ff;
   logic          last_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_read) begin
         omega_out_ff <= omega_rdata_ff;
         done_out_ff  <= 1'b0;
         last_out_ff  <= rd_last_ff;
      end else if (cmd.rsp_done) begin
         omega_out_ff <= '0;
         done_out_ff  <= 1'b1;
         last_out_ff  <= 1'b0;
      end
   end

   assign omega_value = omega_out_ff;
   assign omega_peak  = peak_ff;
   assign grid_done   = done_out_ff;
   assign last_value  = last_out_ff;

   // Status
   assign status.load_end        = load_end;
   assign status.grad_tap_last   = (tap_ff == 4'd3);
   assign status.smooth_tap_last = (tap_ff == 4'd8);
   assign status.last_point      = row_last & col_last;
   assign status.last_pass       = (pass_ff == smoothing_passes - 1'b1);
   assign status.no_passes       = (smoothing_passes == '0);
   assign status.sqrt_done       = sqrt_done;

endmodule

`default_nettype wire

@@ hw/rtl/gms_ctrl.sv @@
// ----------------------------------------------------------------------------
// gms_ctrl
// Sequencer: request handshake, gradient sweep, smoothing and copy sweeps,
// peak sweep and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_func,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output gms_pkg::cmd_type           cmd,
   input  wire gms_pkg::status_type   status
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_READ    = 5'd1;
   localparam logic [4:0] S_G_ADDR  = 5'd2;
   localparam logic [4:0] S_G_ACC   = 5'd3;
   localparam logic [4:0] S_G_SQ    = 5'd4;
   localparam logic [4:0] S_G_MUL   = 5'd5;
   localparam logic [4:0] S_G_START = 5'd6;
   localparam logic [4:0] S_G_ROOT  = 5'd7;
   localparam logic [4:0] S_G_WR    = 5'd8;
   localparam logic [4:0] S_S_ADDR  = 5'd9;
   localparam logic [4:0] S_S_ACC   = 5'd10;
   localparam logic [4:0] S_S_WR    = 5'd11;
   localparam logic [4:0] S_C_ADDR  = 5'd12;
   localparam logic [4:0] S_C_WR    = 5'd13;
   localparam logic [4:0] S_P_ADDR  = 5'd14;
   localparam logic [4:0] S_P_ACC   = 5'd15;
   localparam logic [4:0] S_DONE    = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.omega_rd_sel = gms_pkg::RD_SEL_POINT;
      case (state_ff)
         S_IDLE: begin
            cmd.omega_rd_sel = gms_pkg::RD_SEL_READ;
            if (accept) begin
               if (req_func == gms_pkg::FUNC_READ) begin
                  cmd.read_start = 1'b1;
                  state_in       = S_READ;
               end else begin
                  cmd.load_wr = 1'b1;
                  if (status.load_end) begin
                     cmd.point_init = 1'b1;
                     state_in       = S_G_ADDR;
                  end
               end
            end
         end
         S_READ: begin
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         S_G_ADDR: begin
            state_in = S_G_ACC;
         end
         S_G_ACC: begin
            cmd.grad_capture = 1'b1;
            if (status.grad_tap_last) begin
               state_in = S_G_SQ;
            end else begin
               cmd.tap_next = 1'b1;
               state_in     = S_G_ADDR;
            end
         end
         S_G_SQ: begin
            cmd.grad_square = 1'b1;
            state_in        = S_G_MUL;
         end
         S_G_MUL: begin
            cmd.grad_scale = 1'b1;
            state_in       = S_G_START;
         end
         S_G_START: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_G_ROOT;
         end
         S_G_ROOT: begin
            if (status.sqrt_done) begin
               state_in = S_G_WR;
            end
         end
         S_G_WR: begin
            cmd.omega_wr_grad = 1'b1;
            if (status.last_point) begin
               cmd.point_init = 1'b1;
               if (status.no_passes) begin
                  cmd.peak_clear = 1'b1;
                  state_in       = S_P_ADDR;
               end else begin
                  cmd.pass_init = 1'b1;
                  state_in      = S_S_ADDR;
               end
            end else begin
               cmd.point_next = 1'b1;
               state_in       = S_G_ADDR;
            end
         end
         S_S_ADDR: begin
            cmd.omega_rd_sel = gms_pkg::RD_SEL_TAP;
            state_in         = S_S_ACC;
         end
         S_S_ACC: begin
            cmd.smooth_acc = 1'b1;
            if (status.smooth_tap_last) begin
               state_in = S_S_WR;
            end else begin
               cmd.tap_next = 1'b1;
               state_in     = S_S_ADDR;
            end
         end
         S_S_WR: begin
            cmd.scratch_wr = 1'b1;
            if (status.last_point) begin
               cmd.point_init = 1'b1;
               state_in       = S_C_ADDR;
            end else begin
               cmd.point_next = 1'b1;
               state_in       = S_S_ADDR;
            end
         end
         S_C_ADDR: begin
            state_in = S_C_WR;
         end
         S_C_WR: begin
            cmd.omega_wr_copy = 1'b1;
            if (status.last_point) begin
               cmd.point_init = 1'b1;
               if (status.last_pass) begin
                  cmd.peak_clear = 1'b1;
                  state_in       = S_P_ADDR;
               end else begin
                  cmd.pass_next = 1'b1;
                  state_in      = S_S_ADDR;
               end
            end else begin
               cmd.point_next = 1'b1;
               state_in       = S_C_ADDR;
            end
         end
         S_P_ADDR: begin
            state_in = S_P_ACC;
         end
         S_P_ACC: begin
            cmd.peak_update = 1'b1;
            if (status.last_point) begin
               state_in = S_DONE;
            end else begin
               cmd.point_next = 1'b1;
               state_in       = S_P_ADDR;
            end
         end
         S_DONE: begin
            cmd.rsp_done = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_read || cmd.rsp_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   // A read transfer yields its result once the S_READ state has set the registered result valid
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == gms_pkg::FUNC_READ)) |-> ##2 rsp_tvalid)
      else $error("read result missing");

   // The root unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      status.sqrt_done |-> (state_ff == S_G_ROOT))
      else $error("root finished outside root wait");

   // No request is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with result pending");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/gradient_monitor_smoother_top.sv @@
// A read's result passes through the S_READ state into the result register.
// The load that completes the grid starts the compute sweep, whose length is set by
// the one-bit-per-cycle root unit and the single read port of the monitor store;
// requests stall for its duration.
// Throughput: one item at a time; after a read or a finished grid, a new request is taken once the result is taken.
// Reset (synchronous): registers to defaults, positions and peak to zero; stores not cleared.
// ----------------------------------------------------------------------------
// gradient_monitor_smoother_top
// Arc-length monitor with binomial smoothing: stream port, register port,
// sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_monitor_smoother_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] phi_value
   input  wire logic        req_tuser,    // [0] func
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,    // [23:0] omega_value, [47:24] omega_peak
   output logic             rsp_tuser,    // [0] grid_done
   output logic             rsp_tlast,    // last_value
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers
   logic [gms_pkg::ROW_W-1:0]  row_count_ff;
   logic [gms_pkg::COL_W-1:0]  column_count_ff;
   logic [gms_pkg::GAIN_W-1:0] gradient_gain_ff;
   logic [gms_pkg::PASS_W-1:0] smoothing_passes_ff;
   logic                       csr_write;
   logic [1:0]                 csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff        <= gms_pkg::ROW_W'(150);
         column_count_ff     <= gms_pkg::COL_W'(30);
         gradient_gain_ff    <= gms_pkg::GAIN_W'(400);
         smoothing_passes_ff <= gms_pkg::PASS_W'(4);
      end else if (csr_write) begin
         case (csr_index)
            gms_pkg::REG_ROWS:   row_count_ff        <= csr_pwdata[gms_pkg::ROW_W-1:0];
            gms_pkg::REG_COLS:   column_count_ff     <= csr_pwdata[gms_pkg::COL_W-1:0];
            gms_pkg::REG_GAIN:   gradient_gain_ff    <= csr_pwdata[gms_pkg::GAIN_W-1:0];
            gms_pkg::REG_PASSES: smoothing_passes_ff <= csr_pwdata[gms_pkg::PASS_W-1:0];
            default:             ;
         endcase
      end
   end

   // Register read back
   always_comb begin
      case (csr_index)
         gms_pkg::REG_ROWS:   csr_prdata = 32'(row_count_ff);
         gms_pkg::REG_COLS:   csr_prdata = 32'(column_count_ff);
         gms_pkg::REG_GAIN:   csr_prdata = 32'(gradient_gain_ff);
         gms_pkg::REG_PASSES: csr_prdata = 32'(smoothing_passes_ff);
         default:             csr_prdata = '0;
      endcase
   end

   gms_pkg::cmd_type    cmd;
   gms_pkg::status_type status;

   gms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gms_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .row_count        (row_count_ff),
      .column_count     (column_count_ff),
      .gradient_gain    (gradient_gain_ff),
      .smoothing_passes (smoothing_passes_ff),
      .phi_value        (req_tdata),
      .omega_value      (rsp_tdata[23:0]),
      .omega_peak       (rsp_tdata[47:24]),
      .grid_done        (rsp_tuser),
      .last_value       (rsp_tlast)
   );

endmodule

`default_nettype wire
